/* rtl/tcw_pkg.sv */
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int QUEUE_DEPTH     = 2;

   localparam int INDEX_W   = 11;
   localparam int CELL_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [7:0] NEWLINE_CODE   = 8'd10;
   localparam logic [7:0] SPACE_CODE     = 8'h20;
   localparam logic [7:0] COLOR_AT_RESET = 8'h07;

   localparam logic FUNC_READ = 1'b1;

   localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         char_code;
      logic [INDEX_W-1:0] cell_index;
      logic               in_range;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL
   } back_state_type;

endpackage

/* rtl/tcw_front.sv */
// front end: accepts request transfers and classifies them into commands
`timescale 1ns / 1ps

module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [7:0]         req_char_code,
   input  logic [INDEX_W-1:0] req_cell_index,
   input  queue_status_type   q_stat,
   input  back_status_type    back_stat,
   output logic               push,
   output cmd_type            push_cmd
);

   localparam int CELL_COUNT = ROWS * COLUMNS;

   assign req_ready = !q_stat.full && !back_stat.clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      if (req_func == FUNC_READ) begin
         push_cmd.kind = CMD_READ;
      end else if (req_char_code == NEWLINE_CODE) begin
         push_cmd.kind = CMD_NEWLINE;
      end else begin
         push_cmd.kind = CMD_PUT;
      end
      push_cmd.char_code  = req_char_code;
      push_cmd.cell_index = req_cell_index;
      push_cmd.in_range   = (32'(req_cell_index) < 32'(CELL_COUNT));
   end

endmodule

/* rtl/tcw_queue.sv */
// short command queue between front end and back end
`timescale 1ns / 1ps

module tcw_queue
   import tcw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/tcw_back.sv */
// back end: screen store, cursor, scroll and clear sequencer, response register
`timescale 1ns / 1ps

module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           text_color,
   input  queue_status_type     q_stat,
   input  cmd_type              head_cmd,
   output logic                 pop,
   output back_status_type      back_stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CELL_W-1:0]    rsp_read_cell,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [COL_OUT_W-1:0] rsp_cursor_col,
   output logic                 rsp_scrolled
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int CELL_LAST  = CELL_COUNT - 1;
   localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);

   logic [CELL_W-1:0] screen_mem [CELL_COUNT];
   logic [CELL_W-1:0] rdata_ff;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_dst_ff, copy_dst_in;
   logic              range_ff, range_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic              rsp_scroll_ff, rsp_scroll_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              load;
   logic              slot_free;
   logic [ADDR_W-1:0] cur_addr;
   logic              col_last;
   logic              row_last;
   logic              row_adv;
   logic [COL_W-1:0]  col_step;
   logic [31:0]       row_wide;
   logic [31:0]       col_wide;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty && slot_free;
   assign cur_addr  = ADDR_W'(int'(row_ff) * COLUMNS) + ADDR_W'(col_ff);
   assign col_last  = (col_ff == COL_W'(COLUMNS - 1));
   assign row_last  = (row_ff == ROW_W'(ROWS - 1));

   assign back_stat.clearing = (state_ff == ST_CLEAR);

   // cursor step for put and newline
   always_comb begin
      row_adv  = 1'b0;
      col_step = col_ff;
      case (head_cmd.kind)
         CMD_PUT: begin
            row_adv  = col_last;
            col_step = col_last ? '0 : col_ff + 1'b1;
         end
         CMD_NEWLINE: begin
            row_adv  = 1'b1;
            col_step = '0;
         end
         default: begin
            row_adv  = 1'b0;
            col_step = col_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == ADDR_W'(CELL_LAST)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop) begin
               if (head_cmd.kind == CMD_READ) begin
                  state_in = ST_READ;
               end else if (row_adv && row_last) begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_COPY: begin
            if (cnt_ff == ADDR_W'(COPY_LAST)) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (!copy_pend_ff && cnt_ff == ADDR_W'(CELL_LAST)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath control
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = {text_color, SPACE_CODE};
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      copy_pend_in  = 1'b0;
      copy_dst_in   = copy_dst_ff;
      range_in      = range_ff;
      load          = 1'b0;
      rsp_cell_in   = rsp_cell_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_scroll_in = rsp_scroll_ff;

      // copy write follows its read in the next cycle
      if (copy_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_dst_ff;
         wr_data = rdata_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {COLOR_AT_RESET, SPACE_CODE};
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (pop) begin
               case (head_cmd.kind)
                  CMD_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(head_cmd.cell_index);
                     range_in = head_cmd.in_range;
                  end
                  CMD_PUT, CMD_NEWLINE: begin
                     if (head_cmd.kind == CMD_PUT) begin
                        wr_en   = 1'b1;
                        wr_addr = cur_addr;
                        wr_data = {text_color, head_cmd.char_code};
                     end
                     col_in = col_step;
                     if (row_adv && row_last) begin
                        cnt_in = '0;
                     end else begin
                        row_in        = row_ff + ROW_W'(row_adv);
                        load          = 1'b1;
                        rsp_cell_in   = '0;
                        rsp_row_in    = row_ff + ROW_W'(row_adv);
                        rsp_col_in    = col_step;
                        rsp_scroll_in = 1'b0;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            load          = 1'b1;
            rsp_cell_in   = range_ff ? rdata_ff : '0;
            rsp_row_in    = row_ff;
            rsp_col_in    = col_ff;
            rsp_scroll_in = 1'b0;
         end
         ST_COPY: begin
            rd_en        = 1'b1;
            rd_addr      = ADDR_W'(int'(cnt_ff) + COLUMNS);
            copy_pend_in = 1'b1;
            copy_dst_in  = cnt_ff;
            cnt_in       = cnt_ff + 1'b1;
         end
         ST_FILL: begin
            if (!copy_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff;
               wr_data = {text_color, SPACE_CODE};
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == ADDR_W'(CELL_LAST)) begin
                  load          = 1'b1;
                  rsp_cell_in   = '0;
                  rsp_row_in    = row_ff;
                  rsp_col_in    = col_ff;
                  rsp_scroll_in = 1'b1;
               end
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff   <= copy_dst_in;
      range_ff      <= range_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= screen_mem[rd_addr];
      end
   end

   assign row_wide       = 32'(rsp_row_ff);
   assign col_wide       = 32'(rsp_col_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_cell  = rsp_cell_ff;
   assign rsp_cursor_row = row_wide[ROW_OUT_W-1:0];
   assign rsp_cursor_col = col_wide[COL_OUT_W-1:0];
   assign rsp_scrolled   = rsp_scroll_ff;

endmodule

/* rtl/text_console_writer_top.sv */
// top level of the text console writer: register port, front end, queue, back end
`timescale 1ns / 1ps

// Text console over a ROWS x COLUMNS store of 16-bit cells (color high byte, character
// low byte) in a single-port-write, registered-read memory. After reset the block clears
// the store to blank cells, one cell per cycle, and req_ready is low while it does so;
// register writes are taken throughout. A put or newline that does not scroll then gives
// its result in the cycle after it leaves the command queue, so one item per cycle is
// sustained while responses are taken; a read passes through the registered memory read
// and then the read state, and the next item waits until it is done. A put or newline
// that moves past the bottom row scrolls: the row copy and the blanking of the bottom row
// share the one write port. The command queue holds two items, so requests are still
// accepted while the back end works or the response waits to be taken.

module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [PADDR_W-1:0]   paddr,
   input  logic [PDATA_W-1:0]   pwdata,
   output logic [PDATA_W-1:0]   prdata,
   output logic                 pready,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_char_code,
   input  logic [INDEX_W-1:0]   req_cell_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CELL_W-1:0]    rsp_read_cell,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [COL_OUT_W-1:0] rsp_cursor_col,
   output logic                 rsp_scrolled
);

   logic [7:0]         color_ff, color_in;
   logic               csr_write;
   logic [PADDR_W-3:0] reg_index;
   logic               push;
   logic               pop;
   cmd_type            push_cmd;
   cmd_type            head_cmd;
   queue_status_type   q_stat;
   back_status_type    back_stat;

   assign pready    = 1'b1;
   assign reg_index = paddr[PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      color_in = color_ff;
      if (csr_write && reg_index == REG_TEXT_COLOR) begin
         color_in = pwdata[7:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_TEXT_COLOR) begin
         prdata = PDATA_W'(color_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_AT_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   tcw_front #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_cell_index(req_cell_index),
      .q_stat        (q_stat),
      .back_stat     (back_stat),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head_cmd(head_cmd),
      .q_stat  (q_stat)
   );

   tcw_back #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .text_color    (color_ff),
      .q_stat        (q_stat),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .back_stat     (back_stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_cell (rsp_read_cell),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_scrolled  (rsp_scrolled)
   );

   a_no_transfer_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !back_stat.clearing
   ) else $error("request transfer accepted during clearing pass");

   a_clear_only_after_reset: assert property (
      @(posedge clock) disable iff (reset)
      !back_stat.clearing |=> !back_stat.clearing
   ) else $error("clearing pass restarted");

   a_scroll_on_bottom_row: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |->
         (32'(rsp_cursor_row) == ((ROWS - 1) & ((1 << ROW_OUT_W) - 1)))
   ) else $error("scroll response with cursor off the bottom row");

   a_scroll_has_no_cell: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_read_cell == '0)
   ) else $error("scroll response carries cell data");

endmodule
